// ----- hw/rtl/float_to_unsigned_truncate_assert.svh -----
// assertion macros for the float to unsigned conversion pipeline
// expects clk and rst_n in the scope of the including module
`ifndef FLOAT_TO_UNSIGNED_TRUNCATE_ASSERT_SVH
`define FLOAT_TO_UNSIGNED_TRUNCATE_ASSERT_SVH

// same-cycle implication
`define F2U_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("f2u: same-cycle check failed");

// next-cycle implication
`define F2U_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("f2u: next-cycle check failed");

`endif

// ----- hw/rtl/f2u_pkg.sv -----
// shared types and constants for the float to unsigned conversion pipeline
// no dependencies
`timescale 1ns / 1ps

package f2u_pkg;

  localparam logic [1:0] KIND_SP   = 2'd0;
  localparam logic [1:0] KIND_DP32 = 2'd1;
  localparam logic [1:0] KIND_DP64 = 2'd2;

  localparam logic [7:0]  SP_BIAS    = 8'h7f;
  localparam logic [7:0]  SP_LIMIT   = 8'h9e;
  localparam logic [10:0] DP_BIAS    = 11'h3ff;
  localparam logic [10:0] DP_LIMIT32 = 11'h41e;
  localparam logic [10:0] DP_LIMIT64 = 11'h43e;

  localparam logic [63:0] ONES32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONES  = 2'd1,
    CLS_SHIFT = 2'd2
  } cls_t;

  // payload between stages: class, width flag, right shift and aligned significand
  typedef struct packed {
    cls_t        cls;
    logic        wide;
    logic [5:0]  sh;
    logic [63:0] mant;
  } dec_t;

endpackage

// ----- hw/rtl/f2u_decode_stage.sv -----
// stage one: classifies the raw bits and left-aligns the significand
// depends on f2u_pkg
`timescale 1ns / 1ps

module f2u_decode_stage import f2u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] float_bits,
  output logic        dn_valid,
  input  logic        dn_ready,
  output dec_t        dn_data
);

  logic        valid_r;
  logic        valid_nxt;
  dec_t        data_r;
  dec_t        data_nxt;
  logic [7:0]  sp_ex;
  logic [7:0]  sp_diff;
  logic [10:0] dp_ex;
  logic [10:0] dp_diff;
  logic [10:0] dp_top;
  logic [5:0]  e;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    sp_ex   = float_bits[30:23];
    sp_diff = sp_ex - SP_BIAS;
    dp_ex   = float_bits[62:52];
    dp_diff = dp_ex - DP_BIAS;
    dp_top  = (kind == KIND_DP32) ? DP_LIMIT32 : DP_LIMIT64;
    data_nxt.wide = 1'b1;
    data_nxt.cls  = CLS_SHIFT;
    e             = 6'd0;
    case (kind)
      KIND_SP: begin
        data_nxt.wide = 1'b0;
        e             = sp_diff[5:0];
        data_nxt.mant = {1'b1, float_bits[22:0], 40'd0};
        if (sp_ex < SP_BIAS) begin
          data_nxt.cls = CLS_ZERO;
        end else if (float_bits[31] || sp_ex > SP_LIMIT) begin
          data_nxt.cls = CLS_ONES;
        end
      end
      default: begin
        // unused kind code runs as double to u64
        data_nxt.wide = (kind != KIND_DP32);
        e             = dp_diff[5:0];
        data_nxt.mant = {1'b1, float_bits[51:0], 11'd0};
        if (dp_ex < DP_BIAS) begin
          data_nxt.cls = CLS_ZERO;
        end else if (float_bits[63] || dp_ex > dp_top) begin
          data_nxt.cls = CLS_ONES;
        end
      end
    endcase
    // value is mant >> (63 - e)
    data_nxt.sh = ~e;
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- hw/rtl/f2u_coarse_stage.sv -----
// stage two: shifts the significand right by whole bytes
// depends on f2u_pkg
`timescale 1ns / 1ps

module f2u_coarse_stage import f2u_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  dec_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dec_t dn_data
);

  logic valid_r;
  logic valid_nxt;
  dec_t data_r;
  dec_t data_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    data_nxt      = up_data;
    data_nxt.mant = up_data.mant >> {up_data.sh[5:3], 3'b000};
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- hw/rtl/f2u_fine_stage.sv -----
// stage three: residual bit shift and final selection into the output register
// depends on f2u_pkg
`timescale 1ns / 1ps

module f2u_fine_stage import f2u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  dec_t        up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [63:0] result
);

  logic        valid_r;
  logic        valid_nxt;
  logic [63:0] result_r;
  logic [63:0] result_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    case (up_data.cls)
      CLS_ZERO:  result_nxt = 64'd0;
      CLS_ONES:  result_nxt = up_data.wide ? ONES64 : ONES32;
      CLS_SHIFT: result_nxt = up_data.mant >> up_data.sh[2:0];
      default:   result_nxt = 64'd0;
    endcase
  end

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result_r <= result_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign result   = result_r;

endmodule

// ----- hw/rtl/float_to_unsigned_truncate.sv -----
// throughput: one transfer per cycle while the output is not stalled, set by the three
// registered stages (decode, byte shift, bit shift and select); a stall holds
// each full stage whose downstream stages are all full
// reset: synchronous active-low rst_n empties the pipeline; no other state
// depends on f2u_pkg, the three stage modules and the assertion macro header
`timescale 1ns / 1ps
`include "float_to_unsigned_truncate_assert.svh"

module float_to_unsigned_truncate import f2u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_float_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result
);

  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic v1;
  logic v2;
  dec_t d1;
  dec_t d2;

  f2u_decode_stage u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (rdy1),
    .kind       (in_kind),
    .float_bits (in_float_bits),
    .dn_valid   (v1),
    .dn_ready   (rdy2),
    .dn_data    (d1)
  );

  f2u_coarse_stage u_coarse (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v1),
    .up_ready (rdy2),
    .up_data  (d1),
    .dn_valid (v2),
    .dn_ready (rdy3),
    .dn_data  (d2)
  );

  f2u_fine_stage u_fine (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (v2),
    .up_ready (rdy3),
    .up_data  (d2),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .result   (out_result)
  );

  assign in_stall = !rdy1;

  // back-pressure reaches the input only when every stage is full
  `F2U_ASSERT_IMP(a_stall_full, in_stall, v1 && v2 && out_valid && out_stall)
  // a held stage keeps its item
  `F2U_ASSERT_NXT(a_s1_hold, v1 && !rdy2, v1 && $stable(d1))
  `F2U_ASSERT_NXT(a_s2_hold, v2 && !rdy3, v2 && $stable(d2))
  // 32-bit modes only shift right by 32 or more
  `F2U_ASSERT_IMP(a_narrow_sh, v1 && d1.cls == CLS_SHIFT && !d1.wide, d1.sh[5])

endmodule

// ----- test/float_to_unsigned_truncate_tb.sv -----
// testbench for float_to_unsigned_truncate: directed edge values, then random conversions
// under random idling, back-to-back transfers and a long output hold-off
// depends on f2u_pkg and the float_to_unsigned_truncate rtl
`timescale 1ns / 1ps

module float_to_unsigned_truncate_tb import f2u_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int IDLE_PCT     = 17;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] bits;
    logic [63:0] value;
  } conversion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_SP;
  logic [63:0] in_float_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_result;

  conversion_t pending_results[$];
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_left = 0;
  int cycle_count = 0;
  int n_sent = 0;
  int n_directed = 0;
  int n_checked = 0;
  int n_mismatch = 0;

  float_to_unsigned_truncate dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_float_bits (in_float_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // truncating conversion of raw ieee bits to an unsigned integer
  function automatic logic [63:0] truncated_value(logic [1:0] kind, logic [63:0] raw);
    logic [63:0] sig;
    int          e;
    int          top;
    bit          wide;
    if (kind == KIND_SP) begin
      e = int'(raw[30:23]);
      sig = {40'b0, 1'b1, raw[22:0]};
      if (e < int'(SP_BIAS)) return '0;
      if (raw[31] || e > int'(SP_LIMIT)) return ONES32;
      if (e <= int'(SP_BIAS) + 23) return sig >> (int'(SP_BIAS) + 23 - e);
      return (sig << (e - int'(SP_BIAS) - 23)) & ONES32;
    end
    // unused kind code falls back to the 64-bit double conversion
    wide = (kind != KIND_DP32);
    top = wide ? int'(DP_LIMIT64) : int'(DP_LIMIT32);
    e = int'(raw[62:52]);
    sig = {11'b0, 1'b1, raw[51:0]};
    if (e < int'(DP_BIAS)) return '0;
    if (raw[63] || e > top) return wide ? ONES64 : ONES32;
    if (e <= int'(DP_BIAS) + 52) return sig >> (int'(DP_BIAS) + 52 - e);
    return sig << (e - int'(DP_BIAS) - 52);
  endfunction

  // random float biased towards the exponents around the conversion boundaries
  function automatic logic [63:0] random_float(logic [1:0] kind);
    logic [63:0] v;
    int          pick;
    int          e;
    v = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (kind == KIND_SP) begin
      if (pick < 70) e = $urandom_range(int'(SP_LIMIT) + 2, int'(SP_BIAS) - 2);
      else if (pick < 80) e = 255;
      else if (pick < 86) e = 0;
      else e = $urandom_range(255);
      v[30:23] = e[7:0];
      if ($urandom_range(3) != 0) v[31] = 1'b0;
      pick = $urandom_range(9);
      if (pick == 0) v[22:0] = '0;
      else if (pick == 1) v[22:0] = '1;
    end else begin
      if (pick < 70) e = $urandom_range(int'(DP_LIMIT64) + 2, int'(DP_BIAS) - 2);
      else if (pick < 80) e = 2047;
      else if (pick < 86) e = 0;
      else e = $urandom_range(2047);
      v[62:52] = e[10:0];
      if ($urandom_range(3) != 0) v[63] = 1'b0;
      pick = $urandom_range(9);
      if (pick == 0) v[51:0] = '0;
      else if (pick == 1) v[51:0] = '1;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    n_mismatch++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_item(logic [1:0] kind, logic [63:0] bits);
    conversion_t c;
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_float_bits <= bits;
    do @(posedge clk); while (in_stall);
    c.kind = kind;
    c.bits = bits;
    c.value = truncated_value(kind, bits);
    pending_results.push_back(c);
    n_sent++;
  endtask

  task automatic send_random_item();
    logic [1:0] kind;
    kind = 2'($urandom_range(3));
    send_item(kind, random_float(kind));
  endtask

  task automatic wait_all_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_special_values();
    // single precision: zeros, subnormals, one, range ends, inf and nans
    send_item(KIND_SP, 64'h0000_0000_0000_0000);
    send_item(KIND_SP, 64'h0000_0000_8000_0000);
    send_item(KIND_SP, 64'h0000_0000_0000_0001);
    send_item(KIND_SP, 64'h0000_0000_8000_0001);
    send_item(KIND_SP, 64'h0000_0000_3F7F_FFFF);
    send_item(KIND_SP, 64'h0000_0000_3F80_0000);
    send_item(KIND_SP, 64'h0000_0000_4F7F_FFFF);
    send_item(KIND_SP, 64'h0000_0000_4F80_0000);
    send_item(KIND_SP, 64'h0000_0000_BF80_0000);
    send_item(KIND_SP, 64'h0000_0000_7F80_0000);
    send_item(KIND_SP, 64'h0000_0000_7FC0_0000);
    send_item(KIND_SP, 64'h0000_0000_FFC0_0000);
    // upper word must be ignored in single mode
    send_item(KIND_SP, 64'hDEAD_BEEF_3F80_0000);
    send_item(KIND_DP32, 64'h3FF0_0000_0000_0000);
    send_item(KIND_DP32, 64'h41EF_FFFF_FFFF_FFFF);
    send_item(KIND_DP32, 64'h41F0_0000_0000_0000);
    send_item(KIND_DP32, 64'hBFE0_0000_0000_0000);
    send_item(KIND_DP32, 64'hC000_0000_0000_0000);
    send_item(KIND_DP64, 64'h43EF_FFFF_FFFF_FFFF);
    send_item(KIND_DP64, 64'h43F0_0000_0000_0000);
    send_item(KIND_DP64, 64'h4330_0000_0000_0000);
    send_item(KIND_DP64, 64'h4340_0000_0000_0001);
    send_item(KIND_DP64, 64'hFFF8_0000_0000_0000);
    send_item(KIND_DP64, 64'h8000_0000_0000_000F);
    send_item(2'd3, 64'h43EF_FFFF_FFFF_FFFF);
    n_directed = n_sent;
  endtask

  task automatic test_random_with_gaps(int count);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (count) send_random_item();
  endtask

  task automatic test_back_to_back(int count);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    repeat (count) send_random_item();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills and stalls
  task automatic test_output_hold();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (40) send_random_item();
    wait_all_done();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= sink_idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // compare every result transfer with the oldest pending conversion
  always @(posedge clk) begin
    conversion_t c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_result));
      end else begin
        c = pending_results.pop_front();
        n_checked++;
        if (out_result !== c.value)
          report_mismatch($sformatf("kind %0d bits %h: got %h, want %h",
                                    c.kind, c.bits, out_result, c.value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("[float_to_unsigned_truncate] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    wait_all_done();
    test_random_with_gaps(180);
    test_back_to_back(120);
    test_output_hold();
    test_random_with_gaps(90);
    wait_all_done();
    $display("%0d conversions sent (%0d directed), %0d results checked, %0d mismatches",
             n_sent, n_directed, n_checked, n_mismatch);
    $display("covered all kinds incl. the unused code, gaps on both sides and a %0d-cycle hold",
             HOLD_CYCLES);
    if (n_mismatch == 0 && pending_results.size() == 0) begin
      $display("[float_to_unsigned_truncate] OK");
    end else begin
      $display("[float_to_unsigned_truncate] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/f2u_pkg.sv
hw/rtl/f2u_decode_stage.sv
hw/rtl/f2u_coarse_stage.sv
hw/rtl/f2u_fine_stage.sv
hw/rtl/float_to_unsigned_truncate.sv
test/float_to_unsigned_truncate_tb.sv
